### sv/bsg_pkg.sv
// Shared constants and types for the balance start gate.
// Holds block bit positions, configuration register indexes and the phase encoding.
// No dependencies.
package bsg_pkg;

    localparam int BLOCK_W    = 10;
    localparam int COUNT_W    = 16;
    localparam int LIMIT_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PHASE_W    = 2;

    // Block reason bit positions
    localparam int BLK_OFF    = 0;
    localparam int BLK_STATE  = 1;
    localparam int BLK_CONFIG = 2;
    localparam int BLK_LLEN   = 3;
    localparam int BLK_RLEN   = 4;
    localparam int BLK_LRATE  = 5;
    localparam int BLK_RRATE  = 6;
    localparam int BLK_LANG   = 7;
    localparam int BLK_RANG   = 8;
    localparam int BLK_BODY   = 9;

    localparam logic [BLOCK_W-1:0] BLK_OFF_MASK  = BLOCK_W'(1) << BLK_OFF;
    localparam logic [BLOCK_W-1:0] BLK_RATE_MASK =
        (BLOCK_W'(1) << BLK_LRATE) | (BLOCK_W'(1) << BLK_RRATE);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE_CYCLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_TOL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEG_ANGLE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_ANGLE    = 3'd4;

    // Phase codes as seen on the result
    localparam logic [PHASE_W-1:0] PHASE_CODE_OFF     = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_PREPARE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_ACTIVE  = 2'd2;

    // Internal gate state, one-hot
    typedef enum logic [2:0] {
        ST_OFF     = 3'b001,
        ST_PREPARE = 3'b010,
        ST_ACTIVE  = 3'b100
    } t_phase;

    // Limits used by the prepare checks
    typedef struct packed {
        logic [COUNT_W-1:0] stable_cycles;
        logic [LIMIT_W-1:0] length_tolerance;
        logic [LIMIT_W-1:0] length_rate_limit;
        logic [LIMIT_W-1:0] leg_angle_limit;
        logic [LIMIT_W-1:0] body_angle_limit;
    } t_limits;

endpackage

### sv/bsg_in_if.sv
// Request channel of the balance start gate: valid/ready plus one tick of sensor data.
// Depends on nothing; VALUE_BITS sets the width of the signed fields.
interface bsg_in_if #(
    parameter int VALUE_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic                         power_on;
    logic                         sources_valid;
    logic signed [VALUE_BITS-1:0] left_length;
    logic signed [VALUE_BITS-1:0] right_length;
    logic signed [VALUE_BITS-1:0] left_target;
    logic signed [VALUE_BITS-1:0] right_target;
    logic signed [VALUE_BITS-1:0] left_rate;
    logic signed [VALUE_BITS-1:0] right_rate;
    logic signed [VALUE_BITS-1:0] left_angle;
    logic signed [VALUE_BITS-1:0] right_angle;
    logic signed [VALUE_BITS-1:0] pitch_angle;

    modport source (
        output valid, power_on, sources_valid, left_length, right_length,
               left_target, right_target, left_rate, right_rate,
               left_angle, right_angle, pitch_angle,
        input  ready
    );

    modport sink (
        input  valid, power_on, sources_valid, left_length, right_length,
               left_target, right_target, left_rate, right_rate,
               left_angle, right_angle, pitch_angle,
        output ready
    );
endinterface

### sv/bsg_out_if.sv
// Result channel of the balance start gate: valid/ready plus phase, reasons, count, errors.
// Depends on nothing; VALUE_BITS sets the width of the error fields.
interface bsg_out_if #(
    parameter int VALUE_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic [1:0]                 phase;
    logic [9:0]                 block_bits;
    logic [15:0]                count_out;
    logic signed [VALUE_BITS:0] left_error;
    logic signed [VALUE_BITS:0] right_error;

    modport source (
        output valid, phase, block_bits, count_out, left_error, right_error,
        input  ready
    );

    modport sink (
        input  valid, phase, block_bits, count_out, left_error, right_error,
        output ready
    );
endinterface

### sv/bsg_check.sv
// Prepare-phase checks: leg length errors and absolute-value limit compares.
// Depends on bsg_pkg.
module bsg_check #(
    parameter int VALUE_BITS = 16
) (
    input  bsg_pkg::t_limits                i_limits,
    input  logic                            i_sources_valid,
    input  logic signed [VALUE_BITS-1:0]    i_left_length,
    input  logic signed [VALUE_BITS-1:0]    i_right_length,
    input  logic signed [VALUE_BITS-1:0]    i_left_target,
    input  logic signed [VALUE_BITS-1:0]    i_right_target,
    input  logic signed [VALUE_BITS-1:0]    i_left_rate,
    input  logic signed [VALUE_BITS-1:0]    i_right_rate,
    input  logic signed [VALUE_BITS-1:0]    i_left_angle,
    input  logic signed [VALUE_BITS-1:0]    i_right_angle,
    input  logic signed [VALUE_BITS-1:0]    i_pitch_angle,
    output logic signed [VALUE_BITS:0]      o_left_error,
    output logic signed [VALUE_BITS:0]      o_right_error,
    output logic [bsg_pkg::BLOCK_W-1:0]     o_block
);
    localparam int EW = VALUE_BITS + 1;
    // compare width: holds any magnitude and any limit
    localparam int CW = (VALUE_BITS + 2 > bsg_pkg::LIMIT_W + 1) ?
                        VALUE_BITS + 2 : bsg_pkg::LIMIT_W + 1;

    logic cfg_fault;

    // True when |v| is strictly above the limit
    function automatic logic over(input logic signed [CW-1:0] v,
                                  input logic [bsg_pkg::LIMIT_W-1:0] lim);
        logic [CW-1:0] mag;
        begin
            mag = v[CW-1] ? CW'(-v) : CW'(v);
            return mag > CW'(lim);
        end
    endfunction

    // Compute length errors one bit wider than the inputs
    assign o_left_error  = EW'(i_left_length) - EW'(i_left_target);
    assign o_right_error = EW'(i_right_length) - EW'(i_right_target);

    // Any zero setting is a configuration fault and masks the limit checks
    assign cfg_fault = (i_limits.stable_cycles == '0) || (i_limits.length_tolerance == '0) ||
                       (i_limits.length_rate_limit == '0) ||
                       (i_limits.leg_angle_limit == '0) || (i_limits.body_angle_limit == '0);

    // Collect block reasons
    always_comb begin
        o_block = '0;
        o_block[bsg_pkg::BLK_STATE] = !i_sources_valid;
        if (cfg_fault) begin
            o_block[bsg_pkg::BLK_CONFIG] = 1'b1;
        end else begin
            o_block[bsg_pkg::BLK_LLEN]  = over(CW'(o_left_error), i_limits.length_tolerance);
            o_block[bsg_pkg::BLK_RLEN]  = over(CW'(o_right_error), i_limits.length_tolerance);
            o_block[bsg_pkg::BLK_LRATE] = over(CW'(i_left_rate), i_limits.length_rate_limit);
            o_block[bsg_pkg::BLK_RRATE] = over(CW'(i_right_rate), i_limits.length_rate_limit);
            o_block[bsg_pkg::BLK_LANG]  = over(CW'(i_left_angle), i_limits.leg_angle_limit);
            o_block[bsg_pkg::BLK_RANG]  = over(CW'(i_right_angle), i_limits.leg_angle_limit);
            o_block[bsg_pkg::BLK_BODY]  = over(CW'(i_pitch_angle), i_limits.body_angle_limit);
        end
    end
endmodule

### sv/bsg_seq.sv
// Gate sequencer: phase state, stable tick counter and held result registers.
// Depends on bsg_pkg; takes block reasons and errors from bsg_check.
module bsg_seq #(
    parameter int VALUE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic                            i_power_on,
    input  logic [bsg_pkg::BLOCK_W-1:0]     i_block,
    input  logic signed [VALUE_BITS:0]      i_left_error,
    input  logic signed [VALUE_BITS:0]      i_right_error,
    input  logic [bsg_pkg::COUNT_W-1:0]     i_stable_cycles,
    output logic [bsg_pkg::PHASE_W-1:0]     o_phase,
    output logic [bsg_pkg::BLOCK_W-1:0]     o_block,
    output logic [bsg_pkg::COUNT_W-1:0]     o_count,
    output logic signed [VALUE_BITS:0]      o_left_error,
    output logic signed [VALUE_BITS:0]      o_right_error
);
    bsg_pkg::t_phase                r_phase, n_phase;
    logic [bsg_pkg::COUNT_W-1:0]    r_count, n_count;
    logic [bsg_pkg::COUNT_W-1:0]    count_inc;
    logic [bsg_pkg::BLOCK_W-1:0]    r_block, n_block;
    logic signed [VALUE_BITS:0]     r_left_err, n_left_err;
    logic signed [VALUE_BITS:0]     r_right_err, n_right_err;

    assign count_inc = (r_count < i_stable_cycles) ? r_count + 1'b1 : r_count;

    // Advance the gate by one tick
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_block     = r_block;
        n_left_err  = r_left_err;
        n_right_err = r_right_err;
        if (i_adv) begin
            if (!i_power_on) begin
                n_phase = bsg_pkg::ST_OFF;
                n_count = '0;
                n_block = bsg_pkg::BLK_OFF_MASK;
            end else if (r_phase == bsg_pkg::ST_ACTIVE) begin
                n_block = '0;
            end else begin
                n_phase     = bsg_pkg::ST_PREPARE;
                n_block     = i_block;
                n_left_err  = i_left_error;
                n_right_err = i_right_error;
                if (i_block != '0) begin
                    // rate-only blocks back off the count, anything else restarts it
                    if (((i_block & ~bsg_pkg::BLK_RATE_MASK) == '0) && (r_count != '0)) begin
                        n_count = r_count - 1'b1;
                    end else begin
                        n_count = '0;
                    end
                end else begin
                    n_count = count_inc;
                    if (count_inc >= i_stable_cycles) begin
                        n_phase = bsg_pkg::ST_ACTIVE;
                    end
                end
            end
        end
    end

    // Hold state and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= bsg_pkg::ST_OFF;
            r_count     <= '0;
            r_block     <= '0;
            r_left_err  <= '0;
            r_right_err <= '0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_block     <= n_block;
            r_left_err  <= n_left_err;
            r_right_err <= n_right_err;
        end
    end

    // Map the one-hot state to the result code
    always_comb begin
        unique case (r_phase)
            bsg_pkg::ST_OFF:     o_phase = bsg_pkg::PHASE_CODE_OFF;
            bsg_pkg::ST_PREPARE: o_phase = bsg_pkg::PHASE_CODE_PREPARE;
            bsg_pkg::ST_ACTIVE:  o_phase = bsg_pkg::PHASE_CODE_ACTIVE;
            default:             o_phase = bsg_pkg::PHASE_CODE_OFF;
        endcase
    end

    assign o_block       = r_block;
    assign o_count       = r_count;
    assign o_left_error  = r_left_err;
    assign o_right_error = r_right_err;

    // Power off forces the off reason and a cleared count
    a_off_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && !i_power_on |=> (r_block == bsg_pkg::BLK_OFF_MASK) && (r_count == '0))
        else $error("off tick did not clear count or set off reason");

    // Once active with power on, reasons stay clear and count holds
    a_active_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_power_on && (r_phase == bsg_pkg::ST_ACTIVE)
        |=> (r_phase == bsg_pkg::ST_ACTIVE) && (r_block == '0) && $stable(r_count))
        else $error("active phase not held");

    // Errors change only on a prepare tick
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_left_err) && $stable(r_right_err) && $stable(r_phase))
        else $error("state changed without an advance");
endmodule

### sv/balance_start_gate_core.sv
// Balance start gate top level: input register, prepare checks, gate sequencer.
// Flow: an accepted request is held in the input register, and its result is registered when the result slot is free.
// Throughput: one request per cycle while each result is taken; a stalled result holds the input stage.
// Reset (i_rst_n low, synchronous): phase off, count 0, errors 0, all limits 0.
// Depends on bsg_pkg, bsg_in_if, bsg_out_if, bsg_check, bsg_seq.
module balance_start_gate_core #(
    parameter int VALUE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bsg_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bsg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    bsg_in_if.sink                              s_in,
    bsg_out_if.source                           m_out
);
    bsg_pkg::t_limits               r_limits;

    logic                           r_in_valid;
    logic                           r_out_valid;
    logic                           r_power_on;
    logic                           r_sources_valid;
    logic signed [VALUE_BITS-1:0]   r_left_length, r_right_length;
    logic signed [VALUE_BITS-1:0]   r_left_target, r_right_target;
    logic signed [VALUE_BITS-1:0]   r_left_rate, r_right_rate;
    logic signed [VALUE_BITS-1:0]   r_left_angle, r_right_angle, r_pitch_angle;

    logic                           in_take;
    logic                           out_free;
    logic                           adv;
    logic signed [VALUE_BITS:0]     chk_left_err, chk_right_err;
    logic [bsg_pkg::BLOCK_W-1:0]    chk_block;

    // Handshake: advance when the input stage holds a request and the result slot is free
    assign out_free    = !r_out_valid || m_out.ready;
    assign adv         = r_in_valid && out_free;
    assign s_in.ready  = !r_in_valid || adv;
    assign in_take     = s_in.valid && s_in.ready;
    assign m_out.valid = r_out_valid;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsg_pkg::CFG_STABLE_CYCLES: r_limits.stable_cycles <= i_cfg_data;
                bsg_pkg::CFG_LENGTH_TOL:
                    r_limits.length_tolerance <= i_cfg_data[bsg_pkg::LIMIT_W-1:0];
                bsg_pkg::CFG_RATE_LIMIT:
                    r_limits.length_rate_limit <= i_cfg_data[bsg_pkg::LIMIT_W-1:0];
                bsg_pkg::CFG_LEG_ANGLE:
                    r_limits.leg_angle_limit <= i_cfg_data[bsg_pkg::LIMIT_W-1:0];
                bsg_pkg::CFG_BODY_ANGLE:
                    r_limits.body_angle_limit <= i_cfg_data[bsg_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Track valid flags of the input and result stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the request payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_power_on      <= s_in.power_on;
            r_sources_valid <= s_in.sources_valid;
            r_left_length   <= s_in.left_length;
            r_right_length  <= s_in.right_length;
            r_left_target   <= s_in.left_target;
            r_right_target  <= s_in.right_target;
            r_left_rate     <= s_in.left_rate;
            r_right_rate    <= s_in.right_rate;
            r_left_angle    <= s_in.left_angle;
            r_right_angle   <= s_in.right_angle;
            r_pitch_angle   <= s_in.pitch_angle;
        end
    end

    bsg_check #(
        .VALUE_BITS (VALUE_BITS)
    ) u_check (
        .i_limits        (r_limits),
        .i_sources_valid (r_sources_valid),
        .i_left_length   (r_left_length),
        .i_right_length  (r_right_length),
        .i_left_target   (r_left_target),
        .i_right_target  (r_right_target),
        .i_left_rate     (r_left_rate),
        .i_right_rate    (r_right_rate),
        .i_left_angle    (r_left_angle),
        .i_right_angle   (r_right_angle),
        .i_pitch_angle   (r_pitch_angle),
        .o_left_error    (chk_left_err),
        .o_right_error   (chk_right_err),
        .o_block         (chk_block)
    );

    bsg_seq #(
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (adv),
        .i_power_on      (r_power_on),
        .i_block         (chk_block),
        .i_left_error    (chk_left_err),
        .i_right_error   (chk_right_err),
        .i_stable_cycles (r_limits.stable_cycles),
        .o_phase         (m_out.phase),
        .o_block         (m_out.block_bits),
        .o_count         (m_out.count_out),
        .o_left_error    (m_out.left_error),
        .o_right_error   (m_out.right_error)
    );

    // An accepted request sits in the input stage next cycle
    a_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted request lost");

    // Every advance presents a result next cycle
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("advance without a result");

    // A waiting result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_out.ready |-> !adv)
        else $error("result overwritten while stalled");
endmodule
